// ===== design/amdc_pkg.sv =====
// Shared types and constants for the mono DC-blocking high-pass with fade-in.
// Used by the front, queue, back and top-level modules; depends on nothing.
package amdc_pkg;

  // Default sizes, handed down as module parameters from the top level.
  localparam int FRAME_SAMPLES_DEFAULT = 160;
  localparam int RAMP_LEN_DEFAULT      = 320;
  localparam int QUEUE_DEPTH_DEFAULT   = 4;

  // Q15 near-unity used by the fade ramp, and the gain that leaves a sample
  // unchanged after the final shift by 15.
  localparam int          Q15_ONE    = 32767;
  localparam logic [15:0] UNITY_GAIN = 16'h8000;

  // Configuration register indexes and reset values.
  localparam logic REG_WARMUP_FRAMES = 1'b0;
  localparam logic REG_DC_SHIFT      = 1'b1;
  localparam logic [7:0] WARMUP_FRAMES_RESET = 8'd13;
  localparam logic [3:0] DC_SHIFT_RESET      = 4'd8;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_START  = 2'd1,
    OP_STOP   = 2'd2
  } op_t;

  // One classified request waiting between front and back.
  typedef struct packed {
    op_t         kind;
    logic [15:0] mono;
  } entry_t;

  typedef struct packed {
    logic [7:0] warmup_frames;
    logic [3:0] dc_shift;
  } cfg_t;

endpackage

// ===== design/audio_mono_dc_block_fade_in.sv =====
// Results pass the multiply-stage register, then the output register.
// Throughput: one request per cycle unless output stalls; state updates on pop.
// A four-entry queue and a two-register output path let each side stall on its own.
// Reset is synchronous and active high: session off, configuration back to
// 13 warm-up frames and a leak shift of 8, queue and output empty.
module audio_mono_dc_block_fade_in #(
  parameter int FRAME_SAMPLES = amdc_pkg::FRAME_SAMPLES_DEFAULT,
  parameter int RAMP_LEN      = amdc_pkg::RAMP_LEN_DEFAULT,
  parameter int QUEUE_DEPTH   = amdc_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // left_sample [15:0], right_sample [31:16]
  input  logic [1:0]  s_tuser,   // op [1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // mono_out [15:0]
  output logic        m_tlast,   // frame_end
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  amdc_pkg::cfg_t   cfg;
  amdc_pkg::entry_t push_entry;
  amdc_pkg::entry_t pop_entry;
  logic             push;
  logic             q_full;
  logic             q_valid;
  logic             q_pop;
  logic             cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.warmup_frames <= amdc_pkg::WARMUP_FRAMES_RESET;
      cfg.dc_shift      <= amdc_pkg::DC_SHIFT_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        amdc_pkg::REG_WARMUP_FRAMES: cfg.warmup_frames <= pwdata[7:0];
        amdc_pkg::REG_DC_SHIFT:      cfg.dc_shift      <= pwdata[3:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      amdc_pkg::REG_WARMUP_FRAMES: prdata = {24'd0, cfg.warmup_frames};
      amdc_pkg::REG_DC_SHIFT:      prdata = {28'd0, cfg.dc_shift};
      default:                     prdata = 32'd0;
    endcase
  end

  amdc_front u_front (
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  amdc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_entry  (pop_entry)
  );

  amdc_back #(
    .FRAME_SAMPLES (FRAME_SAMPLES),
    .RAMP_LEN      (RAMP_LEN)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_entry  (pop_entry),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

// ===== design/amdc_front.sv =====
// Front end: accepts stream requests, drops unknown opcodes and mixes the
// stereo pair to mono before queueing. Depends on amdc_pkg.
module amdc_front (
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [31:0]          s_tdata,   // left_sample [15:0], right_sample [31:16]
  input  logic [1:0]           s_tuser,   // op [1:0]
  input  logic                 q_full,
  output logic                 push,
  output amdc_pkg::entry_t     push_entry
);

  logic [15:0] left_s;
  logic [15:0] right_s;
  logic [16:0] sum;
  logic [16:0] sum_rounded;
  logic        op_known;

  assign left_s  = s_tdata[15:0];
  assign right_s = s_tdata[31:16];

  // Adding the sign bit before the shift makes the halving round toward zero.
  assign sum         = {left_s[15], left_s} + {right_s[15], right_s};
  assign sum_rounded = sum + {16'd0, sum[16]};

  always_comb begin
    case (s_tuser)
      amdc_pkg::OP_SAMPLE,
      amdc_pkg::OP_START,
      amdc_pkg::OP_STOP: op_known = 1'b1;
      default:           op_known = 1'b0;
    endcase
  end

  assign s_tready        = !q_full;
  assign push            = s_tvalid && !q_full && op_known;
  assign push_entry.kind = amdc_pkg::op_t'(s_tuser);
  assign push_entry.mono = sum_rounded[16:1];

endmodule

// ===== design/amdc_queue.sv =====
// Short register queue that decouples the front end from the back end.
// Depends on amdc_pkg for the entry type.
module amdc_queue #(
  parameter int DEPTH = amdc_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  amdc_pkg::entry_t push_entry,
  output logic             full,
  input  logic             pop,
  output logic             pop_valid,
  output amdc_pkg::entry_t pop_entry
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  amdc_pkg::entry_t mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_pop;

  assign full      = (count == CW'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_entry = mem[rd_ptr];
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({push, do_pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== design/amdc_back.sv =====
// Back end: session control, DC blocker, warm-up discard and fade-in ramp,
// followed by a multiply stage and the output register. Depends on amdc_pkg.
module amdc_back #(
  parameter int FRAME_SAMPLES = amdc_pkg::FRAME_SAMPLES_DEFAULT,
  parameter int RAMP_LEN      = amdc_pkg::RAMP_LEN_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  amdc_pkg::cfg_t   cfg,
  input  logic             q_valid,
  input  amdc_pkg::entry_t q_entry,
  output logic             q_pop,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [15:0]      m_tdata,   // mono_out [15:0]
  output logic             m_tlast    // frame_end
);

  localparam int FPW = $clog2(FRAME_SAMPLES + 1);
  localparam int FCW = $clog2(RAMP_LEN + 1);
  localparam int GRW = $clog2(RAMP_LEN + 1);
  localparam int GAIN_STEP_Q = amdc_pkg::Q15_ONE / RAMP_LEN;
  localparam int GAIN_STEP_R = amdc_pkg::Q15_ONE % RAMP_LEN;

  // Session and filter state.
  logic           running;
  logic [15:0]    dc_prev_in;
  logic [31:0]    dc_prev_out;
  logic [7:0]     warmup_left;
  logic [FPW-1:0] frame_pos;
  logic           fade_active;
  logic [FCW-1:0] fade_count;
  logic [15:0]    gain_q;
  logic [GRW-1:0] gain_r;

  // Multiply stage and output register.
  logic               s1_valid;
  logic signed [15:0] s1_v;
  logic [15:0]        s1_gain;
  logic               s1_last;
  logic signed [32:0] out_prod;

  logic           advance;
  logic           is_sample;
  logic           emit;
  logic [31:0]    x_ext;
  logic [31:0]    px_ext;
  logic [31:0]    leak;
  logic [31:0]    y;
  logic [15:0]    v_clip;
  logic           frame_last;
  logic [FCW-1:0] fade_count_next;
  logic [GRW:0]   gain_r_sum;
  logic           gain_wrap;
  logic [15:0]    gain_q_next;
  logic [GRW-1:0] gain_r_next;

  assign advance = !m_tvalid || m_tready;
  assign q_pop   = q_valid && advance;

  assign x_ext  = {{16{q_entry.mono[15]}}, q_entry.mono};
  assign px_ext = {{16{dc_prev_in[15]}}, dc_prev_in};
  assign leak   = $signed(dc_prev_out) >>> cfg.dc_shift;
  assign y      = x_ext - px_ext + dc_prev_out - leak;

  always_comb begin
    if ($signed(y) > 32'sd32767) begin
      v_clip = 16'h7fff;
    end else if ($signed(y) < -32'sd32768) begin
      v_clip = 16'h8000;
    end else begin
      v_clip = y[15:0];
    end
  end

  assign frame_last      = (frame_pos == FPW'(FRAME_SAMPLES - 1));
  assign is_sample       = (q_entry.kind == amdc_pkg::OP_SAMPLE) && running;
  assign emit            = is_sample && (warmup_left == '0);
  assign fade_count_next = fade_count + FCW'(1);

  // The ramp gain ((n+1)*32767)/RAMP_LEN is kept as quotient and
  // remainder and stepped by the constant 32767 once per faded sample.
  assign gain_r_sum  = {1'b0, gain_r} + (GRW + 1)'(GAIN_STEP_R);
  assign gain_wrap   = (gain_r_sum >= (GRW + 1)'(RAMP_LEN));
  assign gain_r_next = gain_wrap ? GRW'(gain_r_sum - (GRW + 1)'(RAMP_LEN))
                                 : GRW'(gain_r_sum);
  assign gain_q_next = gain_q + 16'(GAIN_STEP_Q) + {15'd0, gain_wrap};

  always_ff @(posedge clk) begin
    if (rst) begin
      running     <= 1'b0;
      dc_prev_in  <= '0;
      dc_prev_out <= '0;
      warmup_left <= '0;
      frame_pos   <= '0;
      fade_active <= 1'b0;
      fade_count  <= '0;
      gain_q      <= '0;
      gain_r      <= '0;
    end else if (q_pop) begin
      case (q_entry.kind)
        amdc_pkg::OP_START: begin
          if (!running) begin
            running     <= 1'b1;
            dc_prev_in  <= '0;
            dc_prev_out <= '0;
            warmup_left <= cfg.warmup_frames;
            frame_pos   <= '0;
            fade_active <= 1'b0;
            fade_count  <= '0;
          end
        end
        amdc_pkg::OP_STOP: begin
          if (running) begin
            running     <= 1'b0;
            dc_prev_in  <= '0;
            dc_prev_out <= '0;
            warmup_left <= '0;
            frame_pos   <= '0;
            fade_active <= 1'b0;
            fade_count  <= '0;
          end
        end
        amdc_pkg::OP_SAMPLE: begin
          if (running) begin
            dc_prev_in  <= q_entry.mono;
            dc_prev_out <= y;
            frame_pos   <= frame_last ? '0 : frame_pos + FPW'(1);
            if (warmup_left != '0) begin
              if (frame_last) begin
                warmup_left <= warmup_left - 8'd1;
                if (warmup_left == 8'd1) begin
                  fade_active <= 1'b1;
                  fade_count  <= '0;
                  gain_q      <= 16'(GAIN_STEP_Q);
                  gain_r      <= GRW'(GAIN_STEP_R);
                end
              end
            end else if (fade_active) begin
              fade_count <= fade_count_next;
              gain_q     <= gain_q_next;
              gain_r     <= gain_r_next;
              if (fade_count_next == FCW'(RAMP_LEN)) begin
                fade_active <= 1'b0;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (advance) begin
      s1_valid <= q_pop && emit;
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_v     <= $signed(v_clip);
      s1_gain  <= fade_active ? gain_q : amdc_pkg::UNITY_GAIN;
      s1_last  <= frame_last;
      out_prod <= 33'(s1_v) * 33'($signed({1'b0, s1_gain}));
      m_tlast  <= s1_last;
    end
  end

  // The gain never exceeds 2^15, so the shifted product always fits 16 bits.
  assign m_tdata = out_prod[30:15];

endmodule

// ===== tb/sv/tb_audio_mono_dc_block_fade_in.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for audio_mono_dc_block_fade_in: drives stereo requests and
// APB register writes, predicts each mono result and compares it on the output stream.
// Depends on amdc_pkg and the block's top level.
module tb_audio_mono_dc_block_fade_in;

  localparam int FRAME_LEN = amdc_pkg::FRAME_SAMPLES_DEFAULT;
  localparam int FADE_LEN  = amdc_pkg::RAMP_LEN_DEFAULT;
  localparam logic [1:0] OP_RESERVED = 2'd3;
  localparam logic [2:0] ADDR_WARMUP   = {amdc_pkg::REG_WARMUP_FRAMES, 2'b00};
  localparam logic [2:0] ADDR_DC_SHIFT = {amdc_pkg::REG_DC_SHIFT, 2'b00};
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int MAX_REPORTS   = 10;

  typedef struct {
    logic [15:0] mono;
    logic        frame_end;
  } mono_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // left_sample [15:0], right_sample [31:16]
  logic [1:0]  s_tuser = '0;   // op [1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // mono_out [15:0]
  logic        m_tlast;        // frame_end
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  audio_mono_dc_block_fade_in #(
    .FRAME_SAMPLES(FRAME_LEN),
    .RAMP_LEN     (FADE_LEN)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #6 clk = ~clk;

  // Predicted block state and configuration copy.
  logic [7:0]         cfg_warmup = amdc_pkg::WARMUP_FRAMES_RESET;
  logic [3:0]         cfg_shift  = amdc_pkg::DC_SHIFT_RESET;
  logic               sess_running = 1'b0;
  logic signed [15:0] hp_prev_in = '0;
  logic [31:0]        hp_prev_out = '0;
  logic [7:0]         warm_left = '0;
  logic [7:0]         frame_pos = '0;
  logic               fade_on = 1'b0;
  logic [8:0]         fade_cnt = '0;

  mono_res_t expected_mono[$];
  int mismatches = 0;
  int sent_items = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int hold_left = 0;
  int sess_dc = 0;

  function automatic longint sat16(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  task automatic clear_session();
    hp_prev_in = '0;
    hp_prev_out = '0;
    warm_left = '0;
    frame_pos = '0;
    fade_on = 1'b0;
    fade_cnt = '0;
  endtask

  // Mixes, filters and fades one accepted request, queuing its result if it has one.
  task automatic mono_filter_step(input logic [1:0] op, input logic signed [15:0] left,
                                  input logic signed [15:0] right);
    int mix;
    longint py, y, v, gain;
    logic last;
    if (op == amdc_pkg::OP_START) begin
      if (!sess_running) begin
        clear_session();
        sess_running = 1'b1;
        warm_left = cfg_warmup;
      end
      return;
    end
    if (op == amdc_pkg::OP_STOP) begin
      if (sess_running) begin
        sess_running = 1'b0;
        clear_session();
      end
      return;
    end
    if (op != amdc_pkg::OP_SAMPLE || !sess_running) return;

    mix = (int'(left) + int'(right)) / 2;
    py = longint'($signed(hp_prev_out));
    y = longint'(mix) - longint'(hp_prev_in) + py - (py >>> cfg_shift);
    hp_prev_in = mix[15:0];
    hp_prev_out = y[31:0];
    v = sat16(longint'($signed(hp_prev_out)));

    last = (frame_pos >= FRAME_LEN - 1);
    frame_pos = last ? 8'd0 : frame_pos + 8'd1;

    if (warm_left > 0) begin
      if (last) begin
        warm_left = warm_left - 8'd1;
        if (warm_left == 0) begin
          fade_on = 1'b1;
          fade_cnt = '0;
        end
      end
      return;
    end

    if (fade_on) begin
      if (fade_cnt < FADE_LEN) begin
        gain = ((longint'(fade_cnt) + 1) * amdc_pkg::Q15_ONE) / FADE_LEN;
        v = sat16((v * gain) >>> 15);
        fade_cnt = fade_cnt + 9'd1;
      end
      if (fade_cnt >= FADE_LEN) fade_on = 1'b0;
    end

    expected_mono.push_back('{mono: v[15:0], frame_end: last});
  endtask

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch (%s): expected %h, got %h", what, want, got);
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Output side: random stalls, plus a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    mono_res_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_mono.size() == 0) begin
        note_mismatch("unexpected result", '0, {15'd0, m_tlast, m_tdata});
      end else begin
        want = expected_mono.pop_front();
        if (m_tdata !== want.mono || m_tlast !== want.frame_end)
          note_mismatch("mono result", {15'd0, want.frame_end, want.mono},
                        {15'd0, m_tlast, m_tdata});
      end
    end
  end

  task automatic send_req(input logic [1:0] op, input logic [15:0] left,
                          input logic [15:0] right);
    if (send_idle_pct > 0) begin
      while ($urandom_range(99) < send_idle_pct) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {right, left};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    mono_filter_step(op, left, right);
    sent_items++;
  endtask

  task automatic wait_results_drained();
    s_tvalid <= 1'b0;
    while (expected_mono.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(input logic write, input logic [2:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= write;
    paddr <= addr;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Unused upper bits of the write data are filled with noise.
  task automatic set_config(input logic [7:0] warm, input logic [3:0] shift);
    logic [31:0] unused;
    wait_results_drained();
    apb_access(1'b1, ADDR_WARMUP, {24'($urandom()), warm}, unused);
    apb_access(1'b1, ADDR_DC_SHIFT, {28'($urandom()), shift}, unused);
    cfg_warmup = warm;
    cfg_shift = shift;
  endtask

  function automatic logic [15:0] rand_pcm();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) return 16'($urandom());
    if (pick == 1) begin
      case ($urandom_range(3))
        0: return 16'h8000;
        1: return 16'h7FFF;
        2: return 16'hFFFF;
        default: return 16'h0000;
      endcase
    end
    return 16'(sess_dc + int'($urandom_range(4000)) - 2000);
  endfunction

  // A start, a run of samples with some noise and broken restarts, and usually a stop.
  task automatic run_session(input int n_samples, input bit close);
    int roll;
    sess_dc = int'($urandom_range(40000)) - 20000;
    send_req(amdc_pkg::OP_START, 16'($urandom()), 16'($urandom()));
    for (int i = 0; i < n_samples; i++) begin
      roll = $urandom_range(99);
      if (roll < 2) begin
        send_req(OP_RESERVED, 16'($urandom()), 16'($urandom()));
      end else if (roll == 2) begin
        send_req(amdc_pkg::OP_START, 16'($urandom()), 16'($urandom()));
      end else if (roll == 3) begin
        send_req(amdc_pkg::OP_STOP, 16'($urandom()), 16'($urandom()));
        send_req(amdc_pkg::OP_START, 16'($urandom()), 16'($urandom()));
      end
      send_req(amdc_pkg::OP_SAMPLE, rand_pcm(), rand_pcm());
    end
    if (close) send_req(amdc_pkg::OP_STOP, 16'($urandom()), 16'($urandom()));
  endtask

  task automatic test_register_reset();
    logic [31:0] rd;
    apb_access(1'b0, ADDR_WARMUP, '0, rd);
    if (rd !== {24'd0, amdc_pkg::WARMUP_FRAMES_RESET})
      note_mismatch("warmup_frames reset", {24'd0, amdc_pkg::WARMUP_FRAMES_RESET}, rd);
    apb_access(1'b0, ADDR_DC_SHIFT, '0, rd);
    if (rd !== {28'd0, amdc_pkg::DC_SHIFT_RESET})
      note_mismatch("dc_shift reset", {28'd0, amdc_pkg::DC_SHIFT_RESET}, rd);
  endtask

  task automatic test_directed_edges();
    set_config(8'd0, 4'd8);
    send_req(amdc_pkg::OP_SAMPLE, 16'd1234, 16'hFFB3);    // stopped: ignored
    send_req(amdc_pkg::OP_STOP, 16'h0000, 16'h0000);      // stop while stopped
    send_req(OP_RESERVED, 16'hFFFF, 16'hFFFF);
    send_req(amdc_pkg::OP_START, 16'h0000, 16'h0000);
    send_req(amdc_pkg::OP_SAMPLE, 16'h7FFF, 16'h7FFF);
    send_req(amdc_pkg::OP_SAMPLE, 16'h8000, 16'h8000);    // clips low
    send_req(amdc_pkg::OP_SAMPLE, 16'h8000, 16'h7FFF);    // odd negative sum truncates to zero
    send_req(amdc_pkg::OP_SAMPLE, 16'hFFFD, 16'h0000);
    send_req(amdc_pkg::OP_SAMPLE, 16'h0001, 16'h0000);
    send_req(amdc_pkg::OP_SAMPLE, 16'h7FFF, 16'h8000);
    send_req(amdc_pkg::OP_START, 16'hFFFF, 16'hFFFF);     // start while running keeps state
    send_req(OP_RESERVED, 16'h5555, 16'hAAAA);
    repeat (4) send_req(amdc_pkg::OP_SAMPLE, 16'h0000, 16'h0000);
    send_req(amdc_pkg::OP_SAMPLE, 16'hAAAA, 16'h5555);
    send_req(amdc_pkg::OP_STOP, 16'h0000, 16'h0000);
    send_req(amdc_pkg::OP_SAMPLE, 16'h7FFF, 16'h7FFF);    // ignored after stop
    send_req(amdc_pkg::OP_STOP, 16'h0000, 16'h0000);
    // With a leak shift of 0 the leak cancels the feedback: a plain first difference.
    set_config(8'd0, 4'd0);
    send_req(amdc_pkg::OP_START, 16'h0000, 16'h0000);
    send_req(amdc_pkg::OP_SAMPLE, 16'h4000, 16'h4000);
    send_req(amdc_pkg::OP_SAMPLE, 16'h8000, 16'h8000);
    send_req(amdc_pkg::OP_SAMPLE, 16'h7FFF, 16'h7FFF);
    send_req(amdc_pkg::OP_STOP, 16'h0000, 16'h0000);
  endtask

  task automatic test_long_warmup();
    set_config(8'd255, 4'd15);
    run_session(200, 1'b1);
  endtask

  task automatic test_backpressure();
    set_config(8'd0, 4'd8);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 400;
    send_req(amdc_pkg::OP_START, 16'h0000, 16'h0000);
    repeat (150) send_req(amdc_pkg::OP_SAMPLE, rand_pcm(), rand_pcm());
    wait_results_drained();
    repeat (150) send_req(amdc_pkg::OP_SAMPLE, rand_pcm(), rand_pcm());
    send_req(amdc_pkg::OP_STOP, 16'h0000, 16'h0000);
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input logic [7:0] warm, input logic [3:0] shift,
                                     input int n_items);
    int first;
    set_config(warm, shift);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    first = sent_items;
    while (sent_items - first < n_items) begin
      if ($urandom_range(2) == 0) set_config(8'($urandom_range(2)), 4'($urandom_range(15)));
      run_session($urandom_range(40, 480), $urandom_range(3) != 0);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_register_reset();
    test_directed_edges();
    test_long_warmup();
    test_backpressure();
    test_random_traffic(0, 0, 8'd1, 4'd15, 100);
    test_random_traffic(79, 0, 8'd0, 4'd0, 100);
    test_random_traffic(0, 79, 8'd2, 4'd4, 100);
    test_random_traffic(24, 24, 8'd1, 4'd1, 100);
    wait_results_drained();
    if (mismatches == 0 && expected_mono.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/amdc_pkg.sv
design/amdc_front.sv
design/amdc_queue.sv
design/amdc_back.sv
design/audio_mono_dc_block_fade_in.sv
tb/sv/tb_audio_mono_dc_block_fade_in.sv
